// ===== rtl/mps_pkg.sv =====
// ----------------------------------------------------------------------------
// mps_pkg: shared types and constants for the streaming max-pooling block
// Sizes, register indexes, reset values and the control word that travels
// with each item from the counter stage to the compute stage.
// ----------------------------------------------------------------------------
package mps_pkg;

  localparam int DATA_W     = 16;
  localparam int MAX_SIZE   = 1024;
  localparam int ADDR_W     = $clog2(MAX_SIZE);
  localparam int KS_W       = 5;
  localparam int IS_W       = 11;
  localparam int PHASE_W    = 4;
  localparam int KS_MAX     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = IS_W;

  localparam logic [KS_W-1:0] KS_RESET = KS_W'(2);
  localparam logic [IS_W-1:0] IS_RESET = IS_W'(1024);

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE  = 1'b1;

  typedef logic signed [DATA_W-1:0] sample_t;

  // Position of one item inside its window and plane.
  typedef struct packed {
    logic              col_first;
    logic              col_last;
    logic              row_first;
    logic              row_last;
    logic              plane_end;
    logic [ADDR_W-1:0] addr;
  } ctl_t;

  function automatic sample_t smax(input sample_t a, input sample_t b);
    smax = (b > a) ? b : a;
  endfunction

endpackage

// ===== rtl/max_pool_stream.sv =====
// ----------------------------------------------------------------------------
// max_pool_stream: non-overlapping square max pooling over a sample stream
// Each window result passes through the compute register, then the result
// register, before it is offered on out_valid.
// Throughput: one sample per cycle; the block stalls only while a result waits
// and the item in the compute stage has a result of its own to hand over.
// Reset (rst_n low, synchronous): kernel_size = 2, image_size = 1024, counters
// and handshake state cleared; the column store is not cleared.
// ----------------------------------------------------------------------------
module max_pool_stream (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [mps_pkg::DATA_W-1:0] in_sample_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mps_pkg::DATA_W-1:0] out_pooled_value,
  output logic                              out_last_of_plane,
  input  logic                              cfg_we,
  input  logic [mps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers and their clamped working values.
  logic [mps_pkg::KS_W-1:0] kernel_size_r;
  logic [mps_pkg::IS_W-1:0] image_size_r;
  logic [mps_pkg::KS_W-1:0] eff_k;
  logic [mps_pkg::IS_W-1:0] eff_s;

  always_comb begin
    if (kernel_size_r == '0) begin
      eff_k = mps_pkg::KS_W'(1);
    end else if (kernel_size_r > mps_pkg::KS_W'(mps_pkg::KS_MAX)) begin
      eff_k = mps_pkg::KS_W'(mps_pkg::KS_MAX);
    end else begin
      eff_k = kernel_size_r;
    end
    if (image_size_r == '0) begin
      eff_s = mps_pkg::IS_W'(1);
    end else if (image_size_r > mps_pkg::IS_W'(mps_pkg::MAX_SIZE)) begin
      eff_s = mps_pkg::IS_W'(mps_pkg::MAX_SIZE);
    end else begin
      eff_s = image_size_r;
    end
  end

  // Position counters. The window column counter tracks column / kernel
  // incrementally, so the store address needs no divider.
  logic [mps_pkg::ADDR_W-1:0]  col_r, col_nxt;
  logic [mps_pkg::ADDR_W-1:0]  row_r, row_nxt;
  logic [mps_pkg::ADDR_W-1:0]  wcol_r, wcol_nxt;
  logic [mps_pkg::PHASE_W-1:0] cph_r, cph_nxt;
  logic [mps_pkg::PHASE_W-1:0] rph_r, rph_nxt;

  logic           col_last, row_last, row_end, plane_end;
  logic           in_acc;
  mps_pkg::ctl_t  ctl_in;

  assign col_last  = ({1'b0, cph_r} + mps_pkg::KS_W'(1)) == eff_k;
  assign row_last  = ({1'b0, rph_r} + mps_pkg::KS_W'(1)) == eff_k;
  assign row_end   = ({1'b0, col_r} + mps_pkg::IS_W'(1)) >= eff_s;
  assign plane_end = row_end && (({1'b0, row_r} + mps_pkg::IS_W'(1)) >= eff_s);
  assign in_acc    = in_valid && in_ready;

  assign ctl_in.col_first = (cph_r == '0);
  assign ctl_in.col_last  = col_last;
  assign ctl_in.row_first = (rph_r == '0);
  assign ctl_in.row_last  = row_last;
  assign ctl_in.plane_end = plane_end;
  assign ctl_in.addr      = wcol_r;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    wcol_nxt = wcol_r;
    cph_nxt  = cph_r;
    rph_nxt  = rph_r;
    if (col_last) begin
      cph_nxt  = '0;
      wcol_nxt = wcol_r + mps_pkg::ADDR_W'(1);
    end else begin
      cph_nxt = cph_r + mps_pkg::PHASE_W'(1);
    end
    if (row_end) begin
      // A window cut off at the right edge is dropped here.
      col_nxt  = '0;
      wcol_nxt = '0;
      cph_nxt  = '0;
      if (plane_end) begin
        row_nxt = '0;
        rph_nxt = '0;
      end else begin
        row_nxt = row_r + mps_pkg::ADDR_W'(1);
        rph_nxt = row_last ? '0 : rph_r + mps_pkg::PHASE_W'(1);
      end
    end else begin
      col_nxt = col_r + mps_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_size_r <= mps_pkg::KS_RESET;
      image_size_r  <= mps_pkg::IS_RESET;
      col_r  <= '0;
      row_r  <= '0;
      wcol_r <= '0;
      cph_r  <= '0;
      rph_r  <= '0;
    end else if (cfg_we) begin
      // Any register write restarts the plane; the store keeps its contents.
      case (cfg_index)
        mps_pkg::CFG_KERNEL_SIZE: kernel_size_r <= cfg_data[mps_pkg::KS_W-1:0];
        mps_pkg::CFG_IMAGE_SIZE:  image_size_r  <= cfg_data;
        default: ;
      endcase
      col_r  <= '0;
      row_r  <= '0;
      wcol_r <= '0;
      cph_r  <= '0;
      rph_r  <= '0;
    end else if (in_acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      wcol_r <= wcol_nxt;
      cph_r  <= cph_nxt;
      rph_r  <= rph_nxt;
    end
  end

  // Column store: one partial window maximum per output column, read when an
  // item is taken and written when a window's last-column item leaves the
  // compute stage. The next row reads an entry image_size - kernel_size + 1
  // items after its write, so no read races its write if kernel_size < image_size.
  mps_pkg::sample_t col_store [mps_pkg::MAX_SIZE];
  mps_pkg::sample_t rd_r;

  // Compute stage.
  logic             s1_valid_r, s1_valid_nxt;
  mps_pkg::sample_t s1_sample_r;
  mps_pkg::ctl_t    s1_ctl_r;
  mps_pkg::sample_t rm_r, rm_nxt;
  mps_pkg::sample_t win_max;
  logic             emit, s1_adv;

  logic             out_valid_r;
  mps_pkg::sample_t out_pooled_value_r;
  logic             out_last_of_plane_r;

  assign rm_nxt  = s1_ctl_r.col_first ? s1_sample_r : mps_pkg::smax(rm_r, s1_sample_r);
  assign win_max = s1_ctl_r.row_first ? rm_nxt : mps_pkg::smax(rd_r, rm_nxt);
  assign emit    = s1_ctl_r.col_last && s1_ctl_r.row_last;

  // An item without a result always moves on; one with a result needs the
  // output register free or emptying in this cycle.
  assign s1_adv   = s1_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= col_store[wcol_r];
    end
    if (s1_adv && s1_ctl_r.col_last) begin
      col_store[s1_ctl_r.addr] <= win_max;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      rm_r       <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_we) begin
        rm_r <= '0;
      end else if (s1_adv) begin
        rm_r <= rm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_sample_value;
      s1_ctl_r    <= ctl_in;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_pooled_value_r  <= win_max;
      out_last_of_plane_r <= s1_ctl_r.plane_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pooled_value  = out_pooled_value_r;
  assign out_last_of_plane = out_last_of_plane_r;

endmodule

// ===== rtl/mps_checker.sv =====
// ----------------------------------------------------------------------------
// mps_checker: port-level checks for the streaming max-pooling block
// Watches reset, output hold under stall and input readiness.
// ----------------------------------------------------------------------------
module mps_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mps_pkg::DATA_W-1:0] out_pooled_value,
  input logic                              out_last_of_plane
);

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_pooled_value) && $stable(out_last_of_plane))
    else $error("stalled result changed");

  // With the output free or draining, the block always takes a new item.
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output was free");

endmodule

bind max_pool_stream mps_checker u_mps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_pooled_value  (out_pooled_value),
  .out_last_of_plane (out_last_of_plane)
);
